// ----- rtl/core/masc_pkg.sv -----
// Shared types and constants for the magnetometer auto-range scaler.
// Holds the sensitivity tables, the reciprocal multipliers derived from them
// and the codes used by the gain control, the axis scalers and the top level.
`default_nettype none

package masc_pkg;

    // Raw axis width used for sign extension and fixed-point fraction bits.
    localparam int RAW_WIDTH     = 16;
    localparam int FRACTION_BITS = 8;

    localparam int RAW_PORT_W = 16;
    localparam int FIELD_W    = 23;
    localparam int GAIN_W     = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 3;

    localparam int GAIN_LEVELS = 7;
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(GAIN_LEVELS - 1);

    localparam int SAT_LIMIT = 2040;

    // field = round(mag * 100 * 2^F / lsb) is computed as
    // (mag * MUL + 2^(SHIFT-1)) >> SHIFT, with MUL = ceil(100 * 2^(F+SHIFT) / lsb).
    // SHIFT is large enough that the reciprocal error never crosses an integer.
    localparam int SHIFT  = RAW_WIDTH + 12;
    localparam int MUL_W  = FRACTION_BITS + SHIFT - 1;
    localparam int PROD_W = RAW_WIDTH + MUL_W;
    localparam int Q_W    = PROD_W - SHIFT;
    localparam int CMP_W  = (Q_W > FIELD_W + 1) ? Q_W : FIELD_W + 1;

    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (SHIFT - 1);
    localparam logic [CMP_W-1:0]  FIELD_MAX_MAG = (CMP_W'(1) << (FIELD_W - 1)) - CMP_W'(1);
    localparam logic [CMP_W-1:0]  FIELD_MIN_MAG = CMP_W'(1) << (FIELD_W - 1);

    localparam longint unsigned NUM = 64'd100 << (FRACTION_BITS + SHIFT);

    // Sensitivity in counts per gauss for each gain index.
    localparam longint unsigned LSB_XY [GAIN_LEVELS] = '{1100, 855, 670, 450, 400, 330, 230};
    localparam longint unsigned LSB_Z  [GAIN_LEVELS] = '{980, 760, 600, 400, 355, 295, 205};

    typedef logic [MUL_W-1:0] t_mul;

    localparam t_mul MUL_XY [GAIN_LEVELS] = '{
        t_mul'((NUM + LSB_XY[0] - 64'd1) / LSB_XY[0]),
        t_mul'((NUM + LSB_XY[1] - 64'd1) / LSB_XY[1]),
        t_mul'((NUM + LSB_XY[2] - 64'd1) / LSB_XY[2]),
        t_mul'((NUM + LSB_XY[3] - 64'd1) / LSB_XY[3]),
        t_mul'((NUM + LSB_XY[4] - 64'd1) / LSB_XY[4]),
        t_mul'((NUM + LSB_XY[5] - 64'd1) / LSB_XY[5]),
        t_mul'((NUM + LSB_XY[6] - 64'd1) / LSB_XY[6])
    };

    localparam t_mul MUL_Z [GAIN_LEVELS] = '{
        t_mul'((NUM + LSB_Z[0] - 64'd1) / LSB_Z[0]),
        t_mul'((NUM + LSB_Z[1] - 64'd1) / LSB_Z[1]),
        t_mul'((NUM + LSB_Z[2] - 64'd1) / LSB_Z[2]),
        t_mul'((NUM + LSB_Z[3] - 64'd1) / LSB_Z[3]),
        t_mul'((NUM + LSB_Z[4] - 64'd1) / LSB_Z[4]),
        t_mul'((NUM + LSB_Z[5] - 64'd1) / LSB_Z[5]),
        t_mul'((NUM + LSB_Z[6] - 64'd1) / LSB_Z[6])
    };

    typedef enum logic [1:0] {
        ST_NO_DATA      = 2'd0,
        ST_RANGE_RAISED = 2'd1,
        ST_VALID        = 2'd2
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AUTO_RANGE   = 1'd0,
        CFG_INITIAL_GAIN = 1'd1
    } t_cfg_reg;

    // Per-item decision from the gain control.
    typedef struct packed {
        t_status             status;
        logic [GAIN_W-1:0]   gain_now;
    } t_gain_dec;

endpackage

`default_nettype wire

// ----- rtl/core/magnetometer_autorange_scaler_top.sv -----
// Top level of the magnetometer auto-range scaler: input register, gain control,
// three axis scalers and the result register. Depends on masc_pkg,
// masc_gain_ctrl and masc_axis_scale.
//
// Takes one sample per clock and returns one result per sample via the input and
// result registers; the sustained rate of one item per cycle holds while the
// output side is ready. The path that sets the clock is one 16 by 35 bit multiply
// by a table constant per axis, with the three axes in parallel. A ready sample
// whose axis reaches +-2040 counts with auto-ranging on and gain below the top
// raises the gain and is reported as range_raised with zero fields; the next
// sample already sees the new gain. Fields are signed, in 1/256 microtesla,
// rounded to nearest with ties away from zero. Configuration writes are taken at
// any time and must only be issued while no item is in flight.
`default_nettype none

module magnetometer_autorange_scaler_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [masc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [masc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Sample stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: x_raw [15:0], y_raw [31:16], z_raw [47:32]
    input  wire logic [47:0]                       s_axis_tdata,
    // tuser: data_ready [0]
    input  wire logic                              s_axis_tuser,
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: x_field [22:0], y_field [45:23], z_field [68:46], gain_now [71:69]
    output logic      [71:0]                       m_axis_tdata,
    // tuser: status_code [1:0]
    output logic      [1:0]                        m_axis_tuser
);

    localparam int RW = masc_pkg::RAW_PORT_W;
    localparam int FW = masc_pkg::FIELD_W;

    // Input register.
    logic           r_in_valid;
    logic           r_dr;
    logic [RW-1:0]  r_x;
    logic [RW-1:0]  r_y;
    logic [RW-1:0]  r_z;

    // Result register.
    logic                          r_out_valid;
    masc_pkg::t_status             r_status;
    logic [FW-1:0]                 r_fx;
    logic [FW-1:0]                 r_fy;
    logic [FW-1:0]                 r_fz;
    logic [masc_pkg::GAIN_W-1:0]   r_gain_now;

    logic                          advance;
    logic [masc_pkg::GAIN_W-1:0]   gain;
    masc_pkg::t_gain_dec           dec;
    logic [FW-1:0]                 fx;
    logic [FW-1:0]                 fy;
    logic [FW-1:0]                 fz;
    logic                          sat_x;
    logic                          sat_y;
    logic                          sat_z;
    logic                          keep_fields;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_dr <= s_axis_tuser;
            r_x  <= s_axis_tdata[RW-1:0];
            r_y  <= s_axis_tdata[2*RW-1:RW];
            r_z  <= s_axis_tdata[3*RW-1:2*RW];
        end
    end

    masc_gain_ctrl u_gain_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_step       (advance),
        .i_data_ready (r_dr),
        .i_sat_any    (sat_x || sat_y || sat_z),
        .o_gain       (gain),
        .o_dec        (dec)
    );

    masc_axis_scale u_scale_x (
        .i_raw   (r_x),
        .i_mult  (masc_pkg::MUL_XY[gain]),
        .o_field (fx),
        .o_sat   (sat_x)
    );

    masc_axis_scale u_scale_y (
        .i_raw   (r_y),
        .i_mult  (masc_pkg::MUL_XY[gain]),
        .o_field (fy),
        .o_sat   (sat_y)
    );

    masc_axis_scale u_scale_z (
        .i_raw   (r_z),
        .i_mult  (masc_pkg::MUL_Z[gain]),
        .o_field (fz),
        .o_sat   (sat_z)
    );

    assign keep_fields = (dec.status == masc_pkg::ST_VALID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status   <= dec.status;
            r_gain_now <= dec.gain_now;
            r_fx       <= keep_fields ? fx : '0;
            r_fy       <= keep_fields ? fy : '0;
            r_fz       <= keep_fields ? fz : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_gain_now, r_fz, r_fy, r_fx};
    assign m_axis_tuser  = r_status;

endmodule

`default_nettype wire

// ----- rtl/core/masc_axis_scale.sv -----
// One axis of the scaler: magnitude, reciprocal multiply with rounding,
// saturation and sign restore. Also flags a raw reading at the range limit.
// Depends on masc_pkg.
`default_nettype none

module masc_axis_scale (
    input  wire logic [masc_pkg::RAW_PORT_W-1:0] i_raw,
    input  wire logic [masc_pkg::MUL_W-1:0]      i_mult,
    output logic      [masc_pkg::FIELD_W-1:0]    o_field,
    output logic                                 o_sat
);

    logic [masc_pkg::RAW_WIDTH-1:0] raw_rw;
    logic                           neg;
    logic [masc_pkg::RAW_WIDTH-1:0] mag;
    logic [masc_pkg::PROD_W-1:0]    prod;
    logic [masc_pkg::CMP_W-1:0]     q;
    logic [masc_pkg::CMP_W-1:0]     q_sat;

    assign raw_rw = i_raw[masc_pkg::RAW_WIDTH-1:0];
    assign neg    = raw_rw[masc_pkg::RAW_WIDTH-1];
    // The most negative reading maps to 2^(RAW_WIDTH-1), which still fits unsigned.
    assign mag    = neg ? (~raw_rw) + masc_pkg::RAW_WIDTH'(1) : raw_rw;

    assign o_sat = (mag >= masc_pkg::RAW_WIDTH'(masc_pkg::SAT_LIMIT));

    assign prod = masc_pkg::PROD_W'(mag) * masc_pkg::PROD_W'(i_mult) + masc_pkg::ROUND_BIAS;
    assign q    = masc_pkg::CMP_W'(prod[masc_pkg::PROD_W-1:masc_pkg::SHIFT]);

    always_comb begin
        if (neg) begin
            q_sat   = (q > masc_pkg::FIELD_MIN_MAG) ? masc_pkg::FIELD_MIN_MAG : q;
            o_field = masc_pkg::FIELD_W'(0) - q_sat[masc_pkg::FIELD_W-1:0];
        end else begin
            q_sat   = (q > masc_pkg::FIELD_MAX_MAG) ? masc_pkg::FIELD_MAX_MAG : q;
            o_field = q_sat[masc_pkg::FIELD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/masc_gain_ctrl.sv -----
// Gain index state, configuration registers and the per-item range decision.
// Depends on masc_pkg.
`default_nettype none

module masc_gain_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [masc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [masc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_step,
    input  wire logic                              i_data_ready,
    input  wire logic                              i_sat_any,
    output logic      [masc_pkg::GAIN_W-1:0]       o_gain,
    output masc_pkg::t_gain_dec                    o_dec
);

    logic                          r_auto_en;
    logic [masc_pkg::GAIN_W-1:0]   r_gain;
    logic                          raise;
    logic [masc_pkg::GAIN_W-1:0]   cfg_gain;

    assign raise = i_data_ready && r_auto_en && (r_gain < masc_pkg::GAIN_MAX) && i_sat_any;

    assign cfg_gain = (i_cfg_data[masc_pkg::GAIN_W-1:0] > masc_pkg::GAIN_MAX)
                    ? masc_pkg::GAIN_MAX : i_cfg_data[masc_pkg::GAIN_W-1:0];

    always_comb begin
        if (!i_data_ready) begin
            o_dec.status   = masc_pkg::ST_NO_DATA;
            o_dec.gain_now = r_gain;
        end else if (raise) begin
            o_dec.status   = masc_pkg::ST_RANGE_RAISED;
            o_dec.gain_now = r_gain + masc_pkg::GAIN_W'(1);
        end else begin
            o_dec.status   = masc_pkg::ST_VALID;
            o_dec.gain_now = r_gain;
        end
    end

    assign o_gain = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_en <= 1'b0;
            r_gain    <= '0;
        end else if (i_cfg_we) begin
            case (masc_pkg::t_cfg_reg'(i_cfg_addr))
                masc_pkg::CFG_AUTO_RANGE:   r_auto_en <= i_cfg_data[0];
                masc_pkg::CFG_INITIAL_GAIN: r_gain    <= cfg_gain;
                default: ;
            endcase
        end else if (i_step && raise) begin
            r_gain <= r_gain + masc_pkg::GAIN_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for magnetometer_autorange_scaler_top.
// Needs masc_pkg for the status codes, register indexes and field widths.
// Each result is checked against a field-by-field prediction of the autorange scaler.

module testbench;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SAT_COUNTS     = 2040;
    localparam longint FIELD_TOP        = (64'd1 << (masc_pkg::FIELD_W - 1)) - 1;
    localparam longint FIELD_BOTTOM_MAG = 64'd1 << (masc_pkg::FIELD_W - 1);
    localparam int ROUNDS          = 40;
    localparam int ITEMS_PER_ROUND = 42;

    // Sensitivity in counts per gauss for each gain index.
    localparam longint XY_COUNTS [7] = '{1100, 855, 670, 450, 400, 330, 230};
    localparam longint Z_COUNTS  [7] = '{980, 760, 600, 400, 355, 295, 205};

    typedef struct packed {
        masc_pkg::t_status                     status;
        logic signed [masc_pkg::FIELD_W-1:0]   x_field;
        logic signed [masc_pkg::FIELD_W-1:0]   y_field;
        logic signed [masc_pkg::FIELD_W-1:0]   z_field;
        logic [masc_pkg::GAIN_W-1:0]           gain_now;
    } t_field_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [masc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [masc_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // tdata: x_raw [15:0], y_raw [31:16], z_raw [47:32]
    logic [47:0]                      s_axis_tdata;
    // tuser: data_ready [0]
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // tdata: x_field [22:0], y_field [45:23], z_field [68:46], gain_now [71:69]
    logic [71:0]                      m_axis_tdata;
    // tuser: status_code [1:0]
    logic [1:0]                       m_axis_tuser;

    // Predicted state of the gain control.
    logic [masc_pkg::GAIN_W-1:0]      gain_model;
    logic                             auto_range_model;

    t_field_result          pending_fields[$];
    int                     mismatch_count = 0;
    int                     idle_cycles    = 0;
    bit                     steady_flow    = 1'b0;
    int                     samples_sent   = 0;
    int                     settings_written = 0;
    int                     seen_no_data   = 0;
    int                     seen_raised    = 0;
    int                     seen_valid     = 0;

    magnetometer_autorange_scaler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint sign_extend_raw(logic [15:0] raw);
        longint v;
        v = $signed(raw << (16 - masc_pkg::RAW_WIDTH)) >>> (16 - masc_pkg::RAW_WIDTH);
        return v;
    endfunction

    function automatic bit over_range(logic [15:0] raw);
        longint v;
        v = sign_extend_raw(raw);
        return v >= SAT_COUNTS || v <= -SAT_COUNTS;
    endfunction

    // Rounds to nearest with ties away from zero, then saturates to the field range.
    function automatic logic [masc_pkg::FIELD_W-1:0] to_microtesla(logic [15:0] raw,
                                                                   longint counts);
        longint v;
        longint mag;
        longint q;
        v = sign_extend_raw(raw);
        mag = (v < 0) ? -v : v;
        q = (((mag * 100) << masc_pkg::FRACTION_BITS) + counts / 2) / counts;
        if (v < 0) begin
            if (q > FIELD_BOTTOM_MAG)
                q = FIELD_BOTTOM_MAG;
            return masc_pkg::FIELD_W'(-q);
        end
        if (q > FIELD_TOP)
            q = FIELD_TOP;
        return masc_pkg::FIELD_W'(q);
    endfunction

    function automatic t_field_result predict_reading(bit ready, logic [15:0] xr,
                                                      logic [15:0] yr, logic [15:0] zr);
        t_field_result r;
        logic [masc_pkg::GAIN_W-1:0] g;
        r = '0;
        g = (gain_model > masc_pkg::GAIN_MAX) ? masc_pkg::GAIN_MAX : gain_model;
        r.status = masc_pkg::ST_NO_DATA;
        r.gain_now = g;
        if (!ready)
            return r;
        if (auto_range_model && g < masc_pkg::GAIN_MAX &&
            (over_range(xr) || over_range(yr) || over_range(zr))) begin
            gain_model = g + 1'b1;
            r.status = masc_pkg::ST_RANGE_RAISED;
            r.gain_now = gain_model;
            return r;
        end
        r.status  = masc_pkg::ST_VALID;
        r.x_field = to_microtesla(xr, XY_COUNTS[g]);
        r.y_field = to_microtesla(yr, XY_COUNTS[g]);
        r.z_field = to_microtesla(zr, Z_COUNTS[g]);
        return r;
    endfunction

    function automatic void apply_register(masc_pkg::t_cfg_reg idx,
                                           logic [masc_pkg::CFG_DATA_W-1:0] val);
        if (idx == masc_pkg::CFG_AUTO_RANGE)
            auto_range_model = val[0];
        else if (idx == masc_pkg::CFG_INITIAL_GAIN)
            gain_model = (val > masc_pkg::GAIN_MAX) ? masc_pkg::GAIN_MAX : val;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 20)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Writes both registers on consecutive edges; the block must be idle.
    task automatic write_settings(bit auto_on, logic [masc_pkg::CFG_DATA_W-1:0] gain);
        logic [masc_pkg::CFG_DATA_W-1:0] auto_word;
        auto_word = {masc_pkg::CFG_DATA_W'($urandom_range(0, 3)) << 1} | auto_on;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= masc_pkg::CFG_AUTO_RANGE;
        i_cfg_data <= auto_word;
        @(posedge i_clk);
        apply_register(masc_pkg::CFG_AUTO_RANGE, auto_word);
        i_cfg_addr <= masc_pkg::CFG_INITIAL_GAIN;
        i_cfg_data <= gain;
        @(posedge i_clk);
        apply_register(masc_pkg::CFG_INITIAL_GAIN, gain);
        i_cfg_we <= 1'b0;
        settings_written++;
    endtask

    task automatic send_sample(bit ready, logic [15:0] xr, logic [15:0] yr, logic [15:0] zr);
        if (!steady_flow && $urandom_range(0, 99) < 3) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ready;
        s_axis_tdata  <= {zr, yr, xr};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_fields.push_back(predict_reading(ready, xr, yr, zr));
        samples_sent++;
    endtask

    // Lets the pipeline empty before any register write.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 4078) - 2039);
        if (r < 88)
            return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(2036, 2044))
                                               : 16'(-$urandom_range(2036, 2044));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic test_defaults_after_reset();
        // Auto-ranging is off after reset, so even full-scale samples are scaled.
        send_sample(1'b0, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_sample(1'b1, 16'sd32767, -16'sd32768, 16'd0);
        send_sample(1'b1, -16'sd1, 16'sd1, -16'sd32768);
        send_sample(1'b1, 16'sd2040, -16'sd2040, 16'sd2040);
        drain_results();
    endtask

    task automatic test_auto_range_steps();
        write_settings(1'b1, 3'd0);
        send_sample(1'b1, 16'sd2039, -16'sd2039, 16'sd0);
        send_sample(1'b1, 16'sd2040, 16'sd0, 16'sd0);
        send_sample(1'b1, 16'sd0, -16'sd2040, 16'sd0);
        send_sample(1'b1, 16'sd0, 16'sd0, 16'sd2040);
        send_sample(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(1'b1, 16'sd100, -16'sd100, 16'sd1000);
        drain_results();
    endtask

    task automatic test_top_gain_and_clamp();
        // A gain write above the top range loads the top range.
        write_settings(1'b1, 3'd7);
        send_sample(1'b1, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
        drain_results();
        write_settings(1'b1, 3'd5);
        send_sample(1'b1, -16'sd2040, 16'sd0, 16'sd0);
        send_sample(1'b1, -16'sd2040, 16'sd5, -16'sd5);
        drain_results();
    endtask

    task automatic test_small_values_rounding();
        write_settings(1'b0, 3'd2);
        send_sample(1'b1, 16'sd1, -16'sd1, 16'sd3);
        send_sample(1'b1, -16'sd3, 16'sd7, -16'sd7);
        send_sample(1'b1, 16'sd11, -16'sd11, 16'sd15);
        drain_results();
        write_settings(1'b0, 3'd6);
        send_sample(1'b1, 16'sd23, -16'sd41, 16'sd41);
        send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0);
        drain_results();
    endtask

    task automatic test_random_settings();
        bit auto_on;
        logic [masc_pkg::CFG_DATA_W-1:0] gain;
        for (int round = 0; round < ROUNDS; round++) begin
            auto_on = (round % 3) != 0;
            case (round)
                1: gain = 3'd7;
                2: gain = 3'd0;
                3: gain = 3'd6;
                default: gain = masc_pkg::CFG_DATA_W'($urandom_range(0, 7));
            endcase
            // A long stretch where neither side ever idles.
            steady_flow = (round >= 10 && round < 20);
            write_settings(auto_on, gain);
            for (int n = 0; n < ITEMS_PER_ROUND; n++)
                send_sample($urandom_range(0, 99) >= 8, random_axis(), random_axis(),
                            random_axis());
            drain_results();
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 6);
    end

    // Result checker: every transfer on the result side is matched to the oldest prediction.
    always @(posedge i_clk) begin
        t_field_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_fields.size() == 0) begin
                report_mismatch("result transfer with no prediction waiting");
            end else begin
                want = pending_fields.pop_front();
                case (want.status)
                    masc_pkg::ST_NO_DATA:      seen_no_data++;
                    masc_pkg::ST_RANGE_RAISED: seen_raised++;
                    default:                   seen_valid++;
                endcase
                if (m_axis_tuser != want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser, want.status));
                if (m_axis_tdata[22:0] != want.x_field)
                    report_mismatch($sformatf("x_field got %0d want %0d",
                                              $signed(m_axis_tdata[22:0]), want.x_field));
                if (m_axis_tdata[45:23] != want.y_field)
                    report_mismatch($sformatf("y_field got %0d want %0d",
                                              $signed(m_axis_tdata[45:23]), want.y_field));
                if (m_axis_tdata[68:46] != want.z_field)
                    report_mismatch($sformatf("z_field got %0d want %0d",
                                              $signed(m_axis_tdata[68:46]), want.z_field));
                if (m_axis_tdata[71:69] != want.gain_now)
                    report_mismatch($sformatf("gain_now got %0d want %0d",
                                              m_axis_tdata[71:69], want.gain_now));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = masc_pkg::CFG_AUTO_RANGE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        gain_model       = '0;
        auto_range_model = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_after_reset();
        test_auto_range_steps();
        test_top_gain_and_clamp();
        test_small_values_rounding();
        test_random_settings();

        if (pending_fields.size() != 0)
            report_mismatch($sformatf("%0d predictions never matched", pending_fields.size()));
        $display("Sent %0d samples under %0d register settings.", samples_sent,
                 settings_written);
        $display("Results checked: %0d no data, %0d gain raises, %0d scaled.",
                 seen_no_data, seen_raised, seen_valid);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- magnetometer_autorange_scaler_top.f -----
rtl/core/masc_pkg.sv
rtl/core/masc_axis_scale.sv
rtl/core/masc_gain_ctrl.sv
rtl/core/magnetometer_autorange_scaler_top.sv
verif/testbench.sv
